>>> rtl/mctp_pkg.sv
// Package: request/response payload types and request codes for the timer pool.
`timescale 1ns / 1ps
package mctp_pkg;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_QUERY = 3'd3;
  localparam logic [2:0] REQ_CHECK = 3'd4;
  localparam logic [2:0] REQ_DELAY = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  handle;
    logic [31:0] duration;
  } req_t;

  typedef struct packed {
    logic        active;
    logic [31:0] count_value;
    logic        pulse;
    logic        pool_full;
    logic [2:0]  peak_active;
    logic        delay_busy;
  } rsp_t;

  // Status from the slot array back to the top level.
  typedef struct packed {
    logic        was_active;
    logic        active;
    logic [31:0] count_value;
    logic        pool_full;
  } stat_t;

endpackage

>>> rtl/mctp_slots.sv
// Slot array: owner and remaining-count registers with the per-request update.
`timescale 1ns / 1ps
module mctp_slots
  import mctp_pkg::*;
#(
  parameter int SLOTS      = 4,
  parameter int COUNT_BITS = 32,
  parameter int PW         = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  req_t          rq,
  output stat_t         stat,
  output logic [PW-1:0] live_cnt
);

  logic [7:0]            owner          [SLOTS];
  logic [COUNT_BITS-1:0] remaining      [SLOTS];
  logic [7:0]            owner_next     [SLOTS];
  logic [COUNT_BITS-1:0] remaining_next [SLOTS];

  logic [SLOTS-1:0]      hit, free_vec, free1, load_vec, hit_post;
  logic                  h_nz, d_nz, any_hit, claim;
  logic [63:0]           dur_wide;
  logic [COUNT_BITS-1:0] dur_cnt, count_sel, dec;
  logic [COUNT_BITS+31:0] count_ext;
  logic [PW-1:0]         n;

  assign dur_wide = {32'b0, rq.duration};
  assign dur_cnt  = dur_wide[COUNT_BITS-1:0];
  assign h_nz     = (rq.handle != 8'd0);
  assign d_nz     = (dur_cnt != '0);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i]      = h_nz && (owner[i] == rq.handle);
      free_vec[i] = (owner[i] == 8'd0);
    end
  end

  assign any_hit = |hit;
  // lowest free slot
  assign free1   = free_vec & (~free_vec + SLOTS'(1));

  assign claim = h_nz && d_nz &&
                 ((rq.req_type == REQ_START) || ((rq.req_type == REQ_CHECK) && !any_hit));
  assign load_vec = claim ? (any_hit ? hit : free1) : '0;

  always_comb begin
    dec = '0;
    for (int i = 0; i < SLOTS; i++) begin
      owner_next[i]     = owner[i];
      remaining_next[i] = remaining[i];
      case (rq.req_type)
        REQ_TICK: begin
          if (owner[i] != 8'd0) begin
            dec               = remaining[i] - COUNT_BITS'(1);
            remaining_next[i] = dec;
            if (dec == '0) owner_next[i] = 8'd0;
          end
        end
        REQ_START, REQ_CHECK: begin
          if (load_vec[i]) begin
            owner_next[i]     = rq.handle;
            remaining_next[i] = dur_cnt;
          end
        end
        REQ_STOP: begin
          if (hit[i]) owner_next[i] = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // lookup and occupancy after the request has been applied
  always_comb begin
    count_sel = '0;
    n         = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_post[i] = h_nz && (owner_next[i] == rq.handle);
      if (hit_post[i]) count_sel = count_sel | remaining_next[i];
      n = n + PW'(owner_next[i] != 8'd0);
    end
  end

  assign count_ext        = {32'b0, count_sel};
  assign stat.was_active  = any_hit;
  assign stat.active      = |hit_post;
  assign stat.count_value = count_ext[31:0];
  assign stat.pool_full   = claim && !any_hit && !(|free_vec);
  assign live_cnt         = n;

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (rst) begin
        owner[i] <= 8'd0;
      end else if (we) begin
        owner[i] <= owner_next[i];
      end
      if (we) remaining[i] <= remaining_next[i];
    end
  end

endmodule

>>> rtl/multi_slot_countdown_timer_pool.sv
// Top level: countdown timer pool with request register, slot array and response register.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | req_t  (req_type, handle, duration)
//  rsp     | out | rsp_valid/rsp_ready  | rsp_t  (active, count_value, pulse, pool_full,
//          |     |                      |         peak_active, delay_busy)
//
// One request per cycle while rsp is not stalled; a taken request passes the request register,
// then the response register. Slot lookup, decrement and claim for all slots are combinational
// between the two registers, and state is written together with the response register.
// Synchronous reset frees all slots and clears the delay counter and peak mark.
// A stalled response holds the request stage; req_ready drops only when both are full
// and rsp_ready is low.
`timescale 1ns / 1ps
module multi_slot_countdown_timer_pool
  import mctp_pkg::*;
#(
  parameter int SLOTS      = 4,
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int PW = $clog2(SLOTS + 1);

  req_t          rq;
  logic          rq_valid;
  logic          advance, we;
  stat_t         stat;
  logic [PW-1:0] live_cnt;
  logic [PW-1:0] peak, peak_next;
  logic [31:0]   delay, delay_next;
  logic [PW+2:0] peak_ext;
  rsp_t          rsp_next;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !rq_valid || advance;
  assign we        = rq_valid && advance;

  mctp_slots #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .PW         (PW)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .we       (we),
    .rq       (rq),
    .stat     (stat),
    .live_cnt (live_cnt)
  );

  always_comb begin
    delay_next = delay;
    peak_next  = peak;
    case (rq.req_type)
      REQ_TICK: begin
        if (delay != 32'd0) delay_next = delay - 32'd1;
        if (live_cnt > peak) peak_next = live_cnt;
      end
      REQ_DELAY: delay_next = rq.duration;
      default: begin
      end
    endcase
  end

  assign peak_ext = {3'b0, peak_next};

  always_comb begin
    rsp_next.active      = stat.active;
    rsp_next.count_value = stat.count_value;
    rsp_next.pulse       = (rq.req_type == REQ_CHECK) && (rq.handle != 8'd0) &&
                           !stat.was_active;
    rsp_next.pool_full   = stat.pool_full;
    rsp_next.peak_active = (peak_ext > (PW + 3)'(7)) ? 3'd7 : peak_ext[2:0];
    rsp_next.delay_busy  = (delay_next != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      delay     <= 32'd0;
      peak      <= '0;
    end else begin
      if (req_valid && req_ready) begin
        rq_valid <= 1'b1;
      end else if (advance) begin
        rq_valid <= 1'b0;
      end
      if (we) begin
        rsp_valid <= 1'b1;
        delay     <= delay_next;
        peak      <= peak_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) rq <= req;
    if (we) rsp <= rsp_next;
  end

endmodule
